[sv/assert_macros.svh]
// Assertion macros used by the checker file of the Stokes former.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define SPF_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("spf assertion failed");

// Check that a condition implies another one on the next edge.
`define SPF_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("spf assertion failed");

`endif

[sv/spf_pkg.sv]
// Types, codes and helper functions of the Stokes parameter former.
// No dependencies; every module and interface file imports this package.
package spf_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned LANES   = 4;
    localparam int unsigned LANE_W  = 2;
    localparam int unsigned MODE_W  = 3;
    localparam int unsigned CIDX_W  = 3;
    localparam int unsigned CDATA_W = 3;

    localparam logic [MODE_W-1:0] MODE_INSTR  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_DIRECT = 3'd1;
    localparam logic [MODE_W-1:0] MODE_I      = 3'd2;
    localparam logic [MODE_W-1:0] MODE_Q      = 3'd3;
    localparam logic [MODE_W-1:0] MODE_U      = 3'd4;
    localparam logic [MODE_W-1:0] MODE_V      = 3'd5;

    localparam logic [CIDX_W-1:0] CFG_OUT_MODE      = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_CIRCULAR_FEED = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_FIRST_INDEX   = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_SECOND_INDEX  = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_POL_COUNT     = 3'd4;

    localparam logic [2:0] FULL_POL_COUNT = 3'd4;
    localparam logic [WORD_W-1:0] SIGN_MASK = 32'h8000_0000;

    typedef struct packed {
        logic [WORD_W-1:0] corr0_re;
        logic [WORD_W-1:0] corr0_im;
        logic [WORD_W-1:0] corr1_re;
        logic [WORD_W-1:0] corr1_im;
        logic [WORD_W-1:0] corr2_re;
        logic [WORD_W-1:0] corr2_im;
        logic [WORD_W-1:0] corr3_re;
        logic [WORD_W-1:0] corr3_im;
        logic              last_channel;
    } spf_in_t;

    typedef struct packed {
        logic [WORD_W-1:0] out_re;
        logic [WORD_W-1:0] out_im;
        logic              last_of_item;
        logic              end_of_range;
        logic              bad_setup;
    } spf_out_t;

    typedef struct packed {
        logic [MODE_W-1:0] out_mode;
        logic              circular_feed;
        logic [LANE_W-1:0] first_index;
        logic [LANE_W-1:0] second_index;
        logic [2:0]        pol_count;
    } spf_cfg_t;

    function automatic logic is_finite(input logic [WORD_W-1:0] f);
        is_finite = (f[30:23] != 8'hFF);
    endfunction

endpackage

[sv/spf_if.sv]
// Valid/ready channel interfaces for the Stokes parameter former.
// Depends on spf_pkg for the payload structs.
interface spf_in_if;
    import spf_pkg::*;
    logic    valid;
    logic    ready;
    spf_in_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
    modport monitor (input valid, input data, input ready);
endinterface

interface spf_out_if;
    import spf_pkg::*;
    logic     valid;
    logic     ready;
    spf_out_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
    modport monitor (input valid, input data, input ready);
endinterface

[sv/stokes_parameter_former.sv]
// Stokes parameter former: converts per-channel correlation products to an
// output polarization. Channels: items (requests, one channel of four complex
// single-precision products), results (one output visibility per request, or
// four in instrumental mode with four products) and a write-only configuration
// port (cfg_write, cfg_index, cfg_data); requests and results are registered.
// Throughput: one request per cycle in direct and Stokes modes while the
// receiver takes results; instrumental mode emits four results per request,
// so a request waits for all four, paced by the single result register.
// A request is held in the item register while its results leave; the next
// request is taken in the same cycle the last result is registered.
// When the receiver stalls, the result register holds its value, the item
// register fills, and items.ready drops until the result is taken.
// Reset clears the valid flags and loads the register defaults: instrumental
// mode, linear feeds, first index 0, second index 3, four products.
// Configuration must be written only while no request is in flight; the
// block itself does not enforce this.
module stokes_parameter_former
    import spf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    spf_in_if.sink             items,
    spf_out_if.source          results,
    input  logic               cfg_write,
    input  logic [CIDX_W-1:0]  cfg_index,
    input  logic [CDATA_W-1:0] cfg_data
);

    spf_cfg_t          cfg_reg;
    spf_in_t           item_reg;
    logic              item_valid_reg;
    logic [LANE_W-1:0] lane_reg, lane_next;
    spf_out_t          res_reg, res_next;
    logic              res_valid_reg;
    logic              adv, last_lane, item_done, take;

    // Register file: writes land directly, no read-back.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.out_mode      <= MODE_INSTR;
            cfg_reg.circular_feed <= 1'b0;
            cfg_reg.first_index   <= 2'd0;
            cfg_reg.second_index  <= 2'd3;
            cfg_reg.pol_count     <= FULL_POL_COUNT;
        end
        else if (cfg_write) begin
            case (cfg_index)
                CFG_OUT_MODE:      cfg_reg.out_mode      <= cfg_data;
                CFG_CIRCULAR_FEED: cfg_reg.circular_feed <= cfg_data[0];
                CFG_FIRST_INDEX:   cfg_reg.first_index   <= cfg_data[1:0];
                CFG_SECOND_INDEX:  cfg_reg.second_index  <= cfg_data[1:0];
                CFG_POL_COUNT:     cfg_reg.pol_count     <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Advance one lane while an item is held and the result register is free or draining.
    assign adv       = item_valid_reg && (!res_valid_reg || results.ready);
    assign last_lane = !(cfg_reg.out_mode == MODE_INSTR && cfg_reg.pol_count == FULL_POL_COUNT)
                       || (lane_reg == LANE_W'(LANES - 1));
    assign item_done = adv && last_lane;
    assign items.ready = !item_valid_reg || item_done;
    assign take      = items.valid && items.ready;
    assign lane_next = lane_reg + LANE_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            item_valid_reg <= 1'b0;
            lane_reg       <= '0;
        end
        else if (take) begin
            item_valid_reg <= 1'b1;
            lane_reg       <= '0;
        end
        else if (item_done) begin
            item_valid_reg <= 1'b0;
        end
        else if (adv) begin
            lane_reg <= lane_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take) begin
            item_reg <= items.data;
        end
    end

    spf_result_unit u_unit (
        .item      (item_reg),
        .lane      (lane_reg),
        .last_lane (last_lane),
        .cfg       (cfg_reg),
        .res       (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            res_valid_reg <= 1'b0;
        end
        else if (adv) begin
            res_valid_reg <= 1'b1;
        end
        else if (results.ready) begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv) begin
            res_reg <= res_next;
        end
    end

    assign results.valid = res_valid_reg;
    assign results.data  = res_reg;

endmodule

[sv/spf_fadd.sv]
// Single-precision adder, round to nearest even, subnormals kept.
// Depends on spf_pkg; ok is low for non-finite operands or overflow.
module spf_fadd
    import spf_pkg::*;
(
    input  logic [WORD_W-1:0] a,
    input  logic [WORD_W-1:0] b,
    output logic [WORD_W-1:0] sum,
    output logic              ok
);

    function automatic logic [4:0] lzc27(input logic [26:0] v);
        logic [4:0] n;
        logic       hit;
        n = 5'd0;
        hit = 1'b0;
        for (int i = 26; i >= 0; i--) begin
            if (!hit && v[i]) begin
                hit = 1'b1;
            end
            else if (!hit) begin
                n = n + 5'd1;
            end
        end
        lzc27 = n;
    endfunction

    logic [WORD_W-1:0] big, lesser;
    logic [7:0]  e_big, e_small, d, shift, lim;
    logic [23:0] m_big, m_small;
    logic [26:0] ext_small, sh, lost_mask, norm;
    logic        lost, sub;
    logic [27:0] raw;
    logic [4:0]  lz;
    logic [9:0]  e, e_fin;
    logic [24:0] m;
    logic        up, ovf;

    always_comb
    begin
        if (b[30:0] > a[30:0]) begin
            big = b;
            lesser = a;
        end
        else begin
            big = a;
            lesser = b;
        end
        e_big   = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        e_small = (lesser[30:23] == 8'd0) ? 8'd1 : lesser[30:23];
        m_big   = {big[30:23] != 8'd0, big[22:0]};
        m_small = {lesser[30:23] != 8'd0, lesser[22:0]};
        d = e_big - e_small;
        ext_small = {m_small, 3'b000};
        if (d >= 8'd27) begin
            sh = 27'd0;
            lost_mask = 27'd0;
            lost = |m_small;
        end
        else begin
            sh = ext_small >> d;
            lost_mask = (27'd1 << d) - 27'd1;
            lost = |(ext_small & lost_mask);
        end
        sh = sh | {26'd0, lost};
        sub = a[31] ^ b[31];
        if (sub) begin
            raw = {1'b0, m_big, 3'b000} - {1'b0, sh};
        end
        else begin
            raw = {1'b0, m_big, 3'b000} + {1'b0, sh};
        end

        lz = lzc27(raw[26:0]);
        lim = e_big - 8'd1;
        shift = ({3'd0, lz} < lim) ? {3'd0, lz} : lim;
        if (raw[27]) begin
            norm = {raw[27:2], raw[1] | raw[0]};
            e = {2'd0, e_big} + 10'd1;
        end
        else begin
            norm = raw[26:0] << shift;
            e = {2'd0, e_big} - {2'd0, shift};
        end

        // Round to nearest, ties to even.
        up = norm[2] & ((|norm[1:0]) | norm[3]);
        m = {1'b0, norm[26:3]} + {24'd0, up};
        if (m[24]) begin
            e_fin = e + 10'd1;
            sum = {big[31], e_fin[7:0], 23'd0};
        end
        else begin
            e_fin = e;
            sum = {big[31], (m[23] ? e_fin[7:0] : 8'd0), m[22:0]};
        end
        ovf = (e_fin >= 10'd255);
        if (raw == 28'd0) begin
            sum = {a[31] & b[31], 31'd0};
        end
        ok = is_finite(a) && is_finite(b) && !ovf;
    end

endmodule

[sv/spf_result_unit.sv]
// Forms one result from a held item and lane: pass-through, Stokes term or error.
// Depends on spf_pkg and spf_fadd.
module spf_result_unit
    import spf_pkg::*;
(
    input  spf_in_t           item,
    input  logic [LANE_W-1:0] lane,
    input  logic              last_lane,
    input  spf_cfg_t          cfg,
    output spf_out_t          res
);

    logic [WORD_W-1:0] lre [LANES];
    logic [WORD_W-1:0] lim [LANES];
    logic [WORD_W-1:0] ar, ai, br, bi, sr, si, hr, hi, rr, ri;
    logic              ok_r, ok_i, diff, rot;

    function automatic logic [WORD_W-1:0] halve(input logic [WORD_W-1:0] f);
        logic [23:0] v, q;
        logic        up;
        if (f[30:23] >= 8'd2) begin
            halve = {f[31], f[30:23] - 8'd1, f[22:0]};
        end
        else begin
            v = {f[23], f[22:0]};
            q = v >> 1;
            up = v[0] & q[0];
            q = q + {23'd0, up};
            halve = {f[31], 7'd0, q};
        end
    endfunction

    assign lre[0] = item.corr0_re;
    assign lim[0] = item.corr0_im;
    assign lre[1] = item.corr1_re;
    assign lim[1] = item.corr1_im;
    assign lre[2] = item.corr2_re;
    assign lim[2] = item.corr2_im;
    assign lre[3] = item.corr3_re;
    assign lim[3] = item.corr3_im;

    assign ar = lre[cfg.first_index];
    assign ai = lim[cfg.first_index];
    assign br = lre[cfg.second_index] ^ (diff ? SIGN_MASK : '0);
    assign bi = lim[cfg.second_index] ^ (diff ? SIGN_MASK : '0);

    always_comb
    begin
        case (cfg.out_mode)
            MODE_Q:  begin diff = !cfg.circular_feed; rot = 1'b0; end
            MODE_U:  begin diff = cfg.circular_feed;  rot = cfg.circular_feed; end
            MODE_V:  begin diff = 1'b1;               rot = !cfg.circular_feed; end
            default: begin diff = 1'b0;               rot = 1'b0; end
        endcase
    end

    spf_fadd u_add_re (.a(ar), .b(br), .sum(sr), .ok(ok_r));
    spf_fadd u_add_im (.a(ai), .b(bi), .sum(si), .ok(ok_i));

    assign hr = halve(sr);
    assign hi = halve(si);

    always_comb
    begin
        res.last_of_item = last_lane;
        res.end_of_range = last_lane & item.last_channel;
        res.bad_setup    = 1'b0;
        rr = '0;
        ri = '0;
        case (cfg.out_mode)
            MODE_INSTR:
            begin
                if (cfg.pol_count != FULL_POL_COUNT) begin
                    res.bad_setup = 1'b1;
                end
                else begin
                    rr = lre[lane];
                    ri = lim[lane];
                end
            end
            MODE_DIRECT:
            begin
                rr = ar;
                ri = ai;
            end
            MODE_I, MODE_Q, MODE_U, MODE_V:
            begin
                if (ok_r && ok_i) begin
                    rr = rot ? hi : hr;
                    ri = rot ? (hr ^ SIGN_MASK) : hi;
                end
            end
            default:
            begin
                res.bad_setup = 1'b1;
            end
        endcase
        if (!is_finite(rr) || !is_finite(ri)) begin
            rr = '0;
            ri = '0;
        end
        res.out_re = rr;
        res.out_im = ri;
    end

endmodule

[sv/spf_checker.sv]
// Port-level checks of the Stokes parameter former, bound to the top level.
// Depends on spf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module spf_checker
    import spf_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     res_valid,
    input logic     res_ready,
    input spf_out_t res_data
);

    logic finite_out;
    logic zero_out;

    assign finite_out = is_finite(res_data.out_re) && is_finite(res_data.out_im);
    assign zero_out   = (res_data.out_re == '0) && (res_data.out_im == '0);

    `SPF_ASSERT_NEXT(a_hold_stalled, res_valid && !res_ready, res_valid && $stable(res_data))
    `SPF_ASSERT(a_finite_out, res_valid |-> finite_out)
    `SPF_ASSERT(a_bad_is_zero, (res_valid && res_data.bad_setup) |-> (zero_out && res_data.last_of_item))
    `SPF_ASSERT(a_eor_on_last, (res_valid && res_data.end_of_range) |-> res_data.last_of_item)

endmodule

bind stokes_parameter_former spf_checker u_spf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (results.valid),
    .res_ready (results.ready),
    .res_data  (results.data)
);

[sim/tb.sv]
// Testbench for stokes_parameter_former: drives channel requests, predicts every
// output visibility bit for bit, and checks the results port against the prediction.
// Depends on spf_pkg, spf_in_if/spf_out_if and the stokes_parameter_former RTL.
`timescale 1ns / 1ps

module tb;
    import spf_pkg::*;

    // Mode codes with no meaning in the block; they must give an error result.
    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;
    localparam int unsigned       MAG_W         = 280;
    localparam logic [31:0]       QUIET_NAN     = 32'h7FC0_0000;
    localparam int                SETTLE_CYCLES = 8;
    localparam int                CYCLE_LIMIT   = 200000;

    logic clk;
    logic rst_n;
    logic cfg_write;
    logic [CIDX_W-1:0]  cfg_index;
    logic [CDATA_W-1:0] cfg_data;

    spf_in_if  in_ch ();
    spf_out_if out_ch ();

    stokes_parameter_former dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .items     (in_ch),
        .results   (out_ch),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the configuration registers, kept in step with every write.
    spf_cfg_t shadow_cfg;
    // Visibilities still owed by the block, oldest first.
    spf_out_t pending_vis[$];
    int       errors = 0;
    int       cycles = 0;
    // Hold both sides busy-free when set; used to get back-to-back stretches.
    bit       steady_flow;
    // One-shot long stall for the receiver, counted in its own process.
    int       hold_cycles;

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Single-precision arithmetic, done on exact integers.
    // A finite float is an integer multiple of 2^-149, so every operand fits
    // a wide integer at that scale and the sum is exact before rounding.
    // ------------------------------------------------------------------
    function automatic bit word_finite(logic [31:0] f);
        return f[30:23] != 8'hFF;
    endfunction

    function automatic logic [MAG_W-1:0] word_mag(logic [31:0] f);
        if (f[30:23] == 8'h00)
            return MAG_W'(f[22:0]);
        return MAG_W'({1'b1, f[22:0]}) << (f[30:23] - 1);
    endfunction

    // Round sgn * mag * 2^(-149-halve) to nearest-even single precision.
    function automatic logic [31:0] round_single(logic sgn, logic [MAG_W-1:0] mag,
                                                 int halve);
        int               msb;
        int               drop;
        int               lsb_exp;
        logic [MAG_W-1:0] q;
        logic [MAG_W-1:0] rem;
        logic [MAG_W-1:0] half_w;
        msb = -1;
        for (int i = 0; i < MAG_W; i++)
            if (mag[i])
                msb = i;
        if (msb < 0)
            return {sgn, 31'b0};
        drop = (msb > 23) ? msb - 23 : 0;
        if (drop < halve)
            drop = halve;
        q = mag >> drop;
        if (drop > 0)
        begin
            rem    = mag & ((MAG_W'(1) << drop) - 1);
            half_w = MAG_W'(1) << (drop - 1);
            if (rem > half_w || (rem == half_w && q[0]))
                q = q + 1;
        end
        lsb_exp = drop - 149 - halve;
        if (q[24])
        begin
            q       = q >> 1;
            lsb_exp = lsb_exp + 1;
        end
        if (!q[23])
            return {sgn, 8'h00, q[22:0]};      // subnormal or zero
        if (lsb_exp + 150 >= 255)
            return {sgn, 8'hFF, 23'b0};        // overflow to infinity
        return {sgn, 8'(lsb_exp + 150), q[22:0]};
    endfunction

    // (a + b) * 0.5 or (a - b) * 0.5, rounded after the sum and again after halving.
    function automatic logic [31:0] half_combine(logic [31:0] a, logic [31:0] b,
                                                 bit subtract);
        logic             sa;
        logic             sb;
        logic             sgn;
        logic [MAG_W-1:0] ma;
        logic [MAG_W-1:0] mb;
        logic [MAG_W-1:0] total;
        logic [31:0]      sum_w;
        if (!word_finite(a) || !word_finite(b))
            return QUIET_NAN;
        sa = a[31];
        sb = b[31] ^ subtract;
        ma = word_mag(a);
        mb = word_mag(b);
        if (sa == sb)
        begin
            total = ma + mb;
            sgn   = sa;
        end
        else if (ma > mb)
        begin
            total = ma - mb;
            sgn   = sa;
        end
        else if (mb > ma)
        begin
            total = mb - ma;
            sgn   = sb;
        end
        else
        begin
            total = '0;
            sgn   = sa & sb;   // exact cancellation is +0 unless both are -0
        end
        sum_w = round_single(sgn, total, 0);
        if (!word_finite(sum_w))
            return sum_w;
        return round_single(sum_w[31], word_mag(sum_w), 1);
    endfunction

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic void owe_visibility(logic [31:0] re, logic [31:0] im,
                                           bit last, logic eor, bit bad);
        spf_out_t v;
        if (!word_finite(re) || !word_finite(im))
        begin
            re = '0;
            im = '0;
        end
        v.out_re       = re;
        v.out_im       = im;
        v.last_of_item = last;
        v.end_of_range = last ? eor : 1'b0;
        v.bad_setup    = bad;
        pending_vis.push_back(v);
    endfunction

    function automatic void form_visibilities(spf_in_t it);
        logic [31:0] lane_re[4];
        logic [31:0] lane_im[4];
        logic [31:0] vr;
        logic [31:0] vi;
        logic [31:0] swap_w;
        bit          circ;
        bit          subtract;
        bit          rotate;
        lane_re = '{it.corr0_re, it.corr1_re, it.corr2_re, it.corr3_re};
        lane_im = '{it.corr0_im, it.corr1_im, it.corr2_im, it.corr3_im};
        circ = shadow_cfg.circular_feed;
        case (shadow_cfg.out_mode)
            MODE_INSTR:
            begin
                if (shadow_cfg.pol_count != FULL_POL_COUNT)
                    owe_visibility('0, '0, 1'b1, it.last_channel, 1'b1);
                else
                    for (int k = 0; k < LANES; k++)
                        owe_visibility(lane_re[k], lane_im[k], k == LANES - 1,
                                       it.last_channel, 1'b0);
            end
            MODE_DIRECT:
                owe_visibility(lane_re[shadow_cfg.first_index],
                               lane_im[shadow_cfg.first_index],
                               1'b1, it.last_channel, 1'b0);
            MODE_I, MODE_Q, MODE_U, MODE_V:
            begin
                case (shadow_cfg.out_mode)
                    MODE_I:  begin subtract = 0;     rotate = 0;     end
                    MODE_Q:  begin subtract = !circ; rotate = 0;     end
                    MODE_U:  begin subtract = circ;  rotate = circ;  end
                    default: begin subtract = 1;     rotate = !circ; end
                endcase
                vr = half_combine(lane_re[shadow_cfg.first_index],
                                  lane_re[shadow_cfg.second_index], subtract);
                vi = half_combine(lane_im[shadow_cfg.first_index],
                                  lane_im[shadow_cfg.second_index], subtract);
                // multiply by -i: swap parts, negate the new imaginary part
                if (rotate)
                begin
                    swap_w = vr;
                    vr     = vi;
                    vi     = swap_w ^ SIGN_MASK;
                end
                owe_visibility(vr, vi, 1'b1, it.last_channel, 1'b0);
            end
            default:
                owe_visibility('0, '0, 1'b1, it.last_channel, 1'b1);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    // Write one register; call at a rising edge while the block is idle.
    task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CDATA_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            CFG_OUT_MODE:      shadow_cfg.out_mode      = value;
            CFG_CIRCULAR_FEED: shadow_cfg.circular_feed = value[0];
            CFG_FIRST_INDEX:   shadow_cfg.first_index   = value[LANE_W-1:0];
            CFG_SECOND_INDEX:  shadow_cfg.second_index  = value[LANE_W-1:0];
            CFG_POL_COUNT:     shadow_cfg.pol_count     = value;
            default: ;
        endcase
    endtask

    task automatic load_setup(logic [MODE_W-1:0] mode, bit circ, logic [1:0] first_i,
                              logic [1:0] second_i, logic [2:0] pols);
        write_reg(CFG_OUT_MODE, mode);
        write_reg(CFG_CIRCULAR_FEED, CDATA_W'(circ));
        write_reg(CFG_FIRST_INDEX, CDATA_W'(first_i));
        write_reg(CFG_SECOND_INDEX, CDATA_W'(second_i));
        write_reg(CFG_POL_COUNT, pols);
    endtask

    // Offer one request, hold it until taken, then record what it owes.
    task automatic offer_request(spf_in_t it);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        do
            @(posedge clk);
        while (!in_ch.ready);
        form_visibilities(it);
    endtask

    // Drop valid, let every owed visibility drain, then let the block settle.
    task automatic drain_block();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_vis.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [31:0] draw_word();
        logic s;
        s = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 11))
            0:       return {s, 31'b0};
            1:       return {s, 8'hFF, 23'b0};
            2:       return {s, 8'hFF, 23'($urandom)};
            3:       return {s, 8'h00, 23'($urandom)};
            4:       return {s, 8'($urandom_range(8'hFC, 8'hFE)), 23'($urandom)};
            5:       return {s, 8'($urandom_range(1, 3)), 23'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    // Random channel; often the second operand lane mirrors the first so that
    // sums and differences cancel exactly or nearly.
    function automatic spf_in_t draw_channel();
        spf_in_t     it;
        logic [31:0] lane_re[4];
        logic [31:0] lane_im[4];
        for (int k = 0; k < LANES; k++)
        begin
            lane_re[k] = draw_word();
            lane_im[k] = draw_word();
        end
        case ($urandom_range(0, 5))
            0:
            begin
                lane_re[shadow_cfg.second_index] = lane_re[shadow_cfg.first_index];
                lane_im[shadow_cfg.second_index] = lane_im[shadow_cfg.first_index];
            end
            1:
            begin
                lane_re[shadow_cfg.second_index] = lane_re[shadow_cfg.first_index] ^ SIGN_MASK;
                lane_im[shadow_cfg.second_index] = lane_im[shadow_cfg.first_index] ^ SIGN_MASK;
            end
            2:
            begin
                lane_re[shadow_cfg.second_index] = lane_re[shadow_cfg.first_index] + 1;
                lane_im[shadow_cfg.second_index] = lane_im[shadow_cfg.first_index] ^ 32'h1;
            end
            default: ;
        endcase
        it.corr0_re = lane_re[0];
        it.corr0_im = lane_im[0];
        it.corr1_re = lane_re[1];
        it.corr1_im = lane_im[1];
        it.corr2_re = lane_re[2];
        it.corr2_im = lane_im[2];
        it.corr3_re = lane_re[3];
        it.corr3_im = lane_im[3];
        it.last_channel = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic spf_in_t fixed_channel(logic [31:0] re_a, logic [31:0] im_a,
                                              logic [31:0] re_b, logic [31:0] im_b,
                                              logic eor);
        spf_in_t it;
        it.corr0_re = re_a;
        it.corr0_im = im_a;
        it.corr1_re = re_b;
        it.corr1_im = im_b;
        it.corr2_re = ~re_a;
        it.corr2_im = ~im_a;
        it.corr3_re = re_b ^ SIGN_MASK;
        it.corr3_im = im_b;
        it.last_channel = eor;
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Result checker: every taken visibility against the oldest one owed.
    // ------------------------------------------------------------------
    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            errors++;
        end
    endtask

    initial
    begin
        int       stall;
        spf_out_t want;
        spf_out_t got;
        bit       hold_done;
        hold_done    = 1'b0;
        out_ch.ready = 1'b1;
        @(posedge rst_n);
        forever
        begin
            if (hold_cycles > 0 && !hold_done)
            begin
                stall     = hold_cycles;
                hold_done = 1'b1;
            end
            else
                stall = steady_flow ? 0 : $urandom_range(0, 5);
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
                out_ch.ready <= 1'b1;
            end
            do
                @(posedge clk);
            while (!(out_ch.valid && out_ch.ready));
            got = out_ch.data;
            if (pending_vis.size() == 0)
            begin
                $error("unexpected visibility %h %h", got.out_re, got.out_im);
                errors++;
            end
            else
            begin
                want = pending_vis.pop_front();
                check_field("out_re", want.out_re, got.out_re);
                check_field("out_im", want.out_im, got.out_im);
                check_field("last_of_item", 32'(want.last_of_item), 32'(got.last_of_item));
                check_field("end_of_range", 32'(want.end_of_range), 32'(got.end_of_range));
                check_field("bad_setup", 32'(want.bad_setup), 32'(got.bad_setup));
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Reset defaults: four lanes pass through, extreme words included.
    task automatic test_instrumental();
        offer_request(fixed_channel('0, '1, 32'h7F7F_FFFF, 32'h8000_0001, 1'b0));
        offer_request(fixed_channel(32'h7F80_0000, 32'h0000_0001, '1, '0, 1'b1));
        offer_request(draw_channel());
        drain_block();
        // wrong product counts, too few and beyond four
        load_setup(MODE_INSTR, 1'b0, 2'd0, 2'd3, 3'd3);
        offer_request(draw_channel());
        drain_block();
        write_reg(CFG_POL_COUNT, 3'd0);
        offer_request(draw_channel());
        drain_block();
        write_reg(CFG_POL_COUNT, 3'd7);
        offer_request(draw_channel());
        drain_block();
    endtask

    // Every lane selected, with a pol_count of one, which direct mode ignores.
    task automatic test_direct();
        load_setup(MODE_DIRECT, 1'b0, 2'd0, 2'd0, 3'd1);
        for (int k = 0; k < LANES; k++)
        begin
            write_reg(CFG_FIRST_INDEX, CDATA_W'(k));
            offer_request(fixed_channel(32'h3F80_0000 + k, 32'hFF80_0000 >> k,
                                        32'h0000_0003, 32'hC000_0000, k[0]));
            drain_block();
        end
    endtask

    // All four Stokes parameters on both feed types: overflow, subnormal
    // halving, exact cancellation and the same lane used twice.
    task automatic test_stokes();
        for (int m = MODE_I; m <= MODE_V; m++)
            for (int c = 0; c < 2; c++)
            begin
                load_setup(MODE_W'(m), c[0], 2'd0, 2'd1, 3'd4);
                offer_request(fixed_channel(32'h7F7F_FFFF, 32'h0000_0003,
                                            32'h7F7F_FFFF, 32'h8000_0001, c[0]));
                offer_request(fixed_channel(32'h4049_0FDB, 32'h8000_0000,
                                            32'hC049_0FDB, 32'h8000_0000, 1'b1));
                drain_block();
            end
        load_setup(MODE_V, 1'b1, 2'd2, 2'd2, 3'd2);
        offer_request(fixed_channel(32'h0080_0001, 32'h3F80_0001, '0, '0, 1'b0));
        drain_block();
    endtask

    task automatic test_spare_modes();
        load_setup(MODE_SPARE_LO, 1'b0, 2'd1, 2'd2, 3'd4);
        offer_request(draw_channel());
        drain_block();
        write_reg(CFG_OUT_MODE, MODE_SPARE_HI);
        offer_request(draw_channel());
        drain_block();
    endtask

    // Stall the receiver for a long stretch while requests keep coming, so the
    // block fills and drops items.ready; then release at full rate.
    task automatic test_backpressure();
        load_setup(MODE_INSTR, 1'b0, 2'd0, 2'd3, 3'd4);
        steady_flow = 1'b1;
        hold_cycles = 80;
        repeat (12) offer_request(draw_channel());
        drain_block();
        steady_flow = 1'b0;
    endtask

    // Random configurations, each mode at least once, random channels.
    task automatic test_random();
        logic [MODE_W-1:0] mode;
        logic [2:0]        pols;
        for (int phase = 0; phase < 9; phase++)
        begin
            mode = MODE_W'(phase % 8);
            pols = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : FULL_POL_COUNT;
            load_setup(mode, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                       2'($urandom_range(0, 3)), pols);
            steady_flow = (phase % 3 == 2);
            repeat (16) offer_request(draw_channel());
            steady_flow = 1'b0;
            drain_block();
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_write    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        steady_flow  = 1'b0;
        hold_cycles  = 0;
        shadow_cfg.out_mode      = MODE_INSTR;
        shadow_cfg.circular_feed = 1'b0;
        shadow_cfg.first_index   = 2'd0;
        shadow_cfg.second_index  = 2'd3;
        shadow_cfg.pol_count     = FULL_POL_COUNT;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_instrumental();
        test_direct();
        test_stokes();
        test_spare_modes();
        test_backpressure();
        test_random();

        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[filelist.f]
+incdir+sv
sv/spf_pkg.sv
sv/spf_if.sv
sv/spf_fadd.sv
sv/spf_result_unit.sv
sv/stokes_parameter_former.sv
sv/spf_checker.sv
sim/tb.sv
